// ===== src/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg: shared types, constants and helpers
// Fixed-point formats, register indexes and rounding/saturation functions
// used by the sample scaling and low-pass filter block.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int NUM_LANES     = 6;

  // Shift from the Q9.40 and Q10.40 scaled products to the output format.
  localparam int Q40_SHIFT   = 40 - FRACTION_BITS;
  localparam int ACCEL_SHIFT = FRACTION_BITS - 11;
  localparam int GAIN_SHIFT  = 16;

  localparam logic signed [32:0] KG = 33'sd1170127931;
  localparam logic signed [33:0] KT = 34'sd3293232779;
  localparam logic signed [50:0] TEMP_BIAS = 51'sd21 <<< 40;

  localparam logic [2:0] REG_WEAK_GAIN   = 3'd0;
  localparam logic [2:0] REG_STRONG_GAIN = 3'd1;
  localparam logic [2:0] REG_GYRO_OFF_X  = 3'd2;
  localparam logic [2:0] REG_GYRO_OFF_Y  = 3'd3;
  localparam logic [2:0] REG_GYRO_OFF_Z  = 3'd4;

  localparam logic [2:0] CH_TEMP = 3'd6;

  localparam logic [15:0] WEAK_GAIN_RST   = 16'd52429;
  localparam logic [15:0] STRONG_GAIN_RST = 16'd6554;

  typedef struct packed {
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic signed [15:0] temp_raw;
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic signed [15:0] gyro_z_raw;
  } frame_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [31:0] physical_value;
    logic signed [31:0] weak_filtered;
    logic signed [31:0] strong_filtered;
    logic               last;
  } result_t;

  typedef struct packed {
    logic signed [31:0] phys;
    logic signed [31:0] weak_y;
    logic signed [31:0] strong_y;
  } lane_res_t;

  typedef struct packed {
    logic [15:0] weak_gain;
    logic [15:0] strong_gain;
  } gains_t;

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // Arithmetic right shift that rounds to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int s);
    logic signed [63:0] bias;
    logic signed [63:0] t;
    bias = (64'sd1 <<< (s - 1)) - $signed({63'd0, v[63]});
    t = v + bias;
    return t >>> s;
  endfunction

endpackage

// ===== src/isl_frame_if.sv =====
// ----------------------------------------------------------------------------
// isl_frame_if: input frame channel
// Valid/ready channel that carries one raw sensor frame per transaction.
// ----------------------------------------------------------------------------
interface isl_frame_if;
  import isl_pkg::*;
  logic   valid;
  logic   ready;
  frame_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/isl_result_if.sv =====
// ----------------------------------------------------------------------------
// isl_result_if: result channel
// Valid/ready channel that carries one converted channel per transaction.
// ----------------------------------------------------------------------------
interface isl_result_if;
  import isl_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/imu_sample_scale_lpf_core.sv =====
// ----------------------------------------------------------------------------
// imu_sample_scale_lpf_core: sensor frame scaling with two low-pass filters
// Each lane registers its scaled product, physical value, filter products
// and filter states in turn; the serializer then sends the seven result
// transactions through one output port. One frame at a time: the next
// frame is taken only once the temperature result has been taken.
// Reset: asynchronous, active low; gains return to defaults, offsets and
// filter states to zero.
// ----------------------------------------------------------------------------
module imu_sample_scale_lpf_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  isl_frame_if.sink   frame_i,
  isl_result_if.source result_o
);
  import isl_pkg::*;

  // Configuration registers. Writes to an unknown index are dropped.
  gains_t             gains_q;
  logic signed [15:0] off_x_q, off_y_q, off_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.weak_gain   <= WEAK_GAIN_RST;
      gains_q.strong_gain <= STRONG_GAIN_RST;
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WEAK_GAIN:   gains_q.weak_gain   <= cfg_data_i;
        REG_STRONG_GAIN: gains_q.strong_gain <= cfg_data_i;
        REG_GYRO_OFF_X:  off_x_q <= cfg_data_i;
        REG_GYRO_OFF_Y:  off_y_q <= cfg_data_i;
        REG_GYRO_OFF_Z:  off_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The block holds one frame from its transaction until the temperature
  // result has been taken, since the filter states of the next frame depend
  // on this one.
  logic busy_q;
  logic accept;
  logic run_end;

  assign accept        = frame_i.valid && frame_i.ready;
  assign frame_i.ready = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (run_end) begin
      busy_q <= 1'b0;
    end
  end

  // Six lanes, one per motion channel: accel x, y, z then gyro x, y, z.
  logic signed [15:0] lane_raw [NUM_LANES];
  logic signed [15:0] lane_off [NUM_LANES];
  logic               lane_gyro [NUM_LANES];
  lane_res_t          lane_res [NUM_LANES];
  logic [NUM_LANES-1:0] lane_done;
  logic signed [31:0] temp_val;

  always_comb begin
    lane_raw[0] = frame_i.data.accel_x_raw;
    lane_raw[1] = frame_i.data.accel_y_raw;
    lane_raw[2] = frame_i.data.accel_z_raw;
    lane_raw[3] = frame_i.data.gyro_x_raw;
    lane_raw[4] = frame_i.data.gyro_y_raw;
    lane_raw[5] = frame_i.data.gyro_z_raw;
    lane_off[0] = '0;
    lane_off[1] = '0;
    lane_off[2] = '0;
    lane_off[3] = off_x_q;
    lane_off[4] = off_y_q;
    lane_off[5] = off_z_q;
    lane_gyro[0] = 1'b0;
    lane_gyro[1] = 1'b0;
    lane_gyro[2] = 1'b0;
    lane_gyro[3] = 1'b1;
    lane_gyro[4] = 1'b1;
    lane_gyro[5] = 1'b1;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    isl_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (accept),
      .is_gyro_i (lane_gyro[g]),
      .raw_i     (lane_raw[g]),
      .offset_i  (lane_off[g]),
      .gains_i   (gains_q),
      .res_o     (lane_res[g]),
      .done_o    (lane_done[g])
    );
  end

  isl_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .raw_i   (frame_i.data.temp_raw),
    .temp_o  (temp_val)
  );

  // The serializer starts once every lane has its filter states updated.
  isl_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (&lane_done),
    .lanes_i   (lane_res),
    .temp_i    (temp_val),
    .res_o     (result_o),
    .run_end_o (run_end)
  );
endmodule

// ===== src/isl_lane.sv =====
// ----------------------------------------------------------------------------
// isl_lane: one motion channel
// Converts a raw accelerometer or gyro word and runs the weak and strong
// recursive filters of that channel.
// ----------------------------------------------------------------------------
module isl_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               is_gyro_i,
  input  logic signed [15:0] raw_i,
  input  logic signed [15:0] offset_i,
  input  isl_pkg::gains_t    gains_i,
  output isl_pkg::lane_res_t res_o,
  output logic               done_o
);
  import isl_pkg::*;

  logic [3:0]         stage_q;
  logic signed [16:0] diff;
  logic signed [15:0] neg;
  logic signed [49:0] gprod_q;
  logic signed [31:0] accel_q;
  logic signed [31:0] phys_q;
  logic signed [32:0] wdiff, sdiff;
  logic signed [49:0] wprod_q, sprod_q;
  logic signed [31:0] weak_q, strong_q;

  assign diff  = 17'(raw_i) - 17'(offset_i);
  assign neg   = -raw_i;
  assign wdiff = 33'(weak_q) - 33'(phys_q);
  assign sdiff = 33'(strong_q) - 33'(phys_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= {stage_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gprod_q <= 50'(diff) * 50'(KG);
      accel_q <= 32'(neg) <<< ACCEL_SHIFT;
    end
    if (stage_q[0]) begin
      phys_q <= is_gyro_i ? sat32(rnd_shift(64'(gprod_q), Q40_SHIFT)) : accel_q;
    end
    // g*y + (1-g)*x is formed as x + g*(y-x), one product per filter.
    if (stage_q[1]) begin
      wprod_q <= 50'($signed({1'b0, gains_i.weak_gain})) * 50'(wdiff);
      sprod_q <= 50'($signed({1'b0, gains_i.strong_gain})) * 50'(sdiff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weak_q   <= '0;
      strong_q <= '0;
    end else if (stage_q[2]) begin
      weak_q   <= sat32(rnd_shift((64'(phys_q) <<< GAIN_SHIFT) + 64'(wprod_q),
                                  GAIN_SHIFT));
      strong_q <= sat32(rnd_shift((64'(phys_q) <<< GAIN_SHIFT) + 64'(sprod_q),
                                  GAIN_SHIFT));
    end
  end

  assign res_o.phys     = phys_q;
  assign res_o.weak_y   = weak_q;
  assign res_o.strong_y = strong_q;
  assign done_o         = stage_q[3];
endmodule

// ===== src/isl_temp.sv =====
// ----------------------------------------------------------------------------
// isl_temp: temperature conversion
// Scales the raw die temperature word to degrees C with the fixed offset.
// ----------------------------------------------------------------------------
module isl_temp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] raw_i,
  output logic signed [31:0] temp_o
);
  import isl_pkg::*;

  logic               start_q;
  logic signed [50:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= 51'(raw_i) * 51'(KT) + TEMP_BIAS;
    end
    if (start_q) begin
      temp_o <= sat32(rnd_shift(64'(prod_q), Q40_SHIFT));
    end
  end
endmodule

// ===== src/isl_merge.sv =====
// ----------------------------------------------------------------------------
// isl_merge: result serializer
// Walks the six lanes and the temperature result out as seven transactions.
// ----------------------------------------------------------------------------
module isl_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  isl_pkg::lane_res_t lanes_i [isl_pkg::NUM_LANES],
  input  logic signed [31:0] temp_i,
  isl_result_if.source       res_o,
  output logic               run_end_o
);
  import isl_pkg::*;

  logic [2:0] cnt_q;
  logic       valid_q;
  logic       fire;
  lane_res_t  sel;

  assign fire = valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (fire) begin
      if (cnt_q == CH_TEMP) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_comb begin
    sel = lanes_i[0];
    if (cnt_q != CH_TEMP) begin
      sel = lanes_i[cnt_q];
    end
    res_o.data.channel = cnt_q;
    if (cnt_q == CH_TEMP) begin
      res_o.data.physical_value  = temp_i;
      res_o.data.weak_filtered   = '0;
      res_o.data.strong_filtered = '0;
      res_o.data.last            = 1'b1;
    end else begin
      res_o.data.physical_value  = sel.phys;
      res_o.data.weak_filtered   = sel.weak_y;
      res_o.data.strong_filtered = sel.strong_y;
      res_o.data.last            = 1'b0;
    end
  end

  assign res_o.valid = valid_q;
  assign run_end_o   = fire && (cnt_q == CH_TEMP);
endmodule

// ===== src/isl_checker.sv =====
// ----------------------------------------------------------------------------
// isl_checker: port-level checks
// Sequencing checks on the frame and result channels of the core.
// ----------------------------------------------------------------------------
module isl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_last_i,
  input logic [2:0] out_channel_i
);
  import isl_pkg::*;

  // No frame is taken while results of the previous one are pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> !out_valid_i)
    else $error("frame accepted while results pending");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("ready stayed high after frame");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_last_i) |=>
      (out_valid_i && out_channel_i == $past(out_channel_i) + 3'd1))
    else $error("result burst broken or out of order");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_channel_i == CH_TEMP)))
    else $error("last flag not on temperature result");
endmodule

bind imu_sample_scale_lpf_core isl_checker u_isl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (frame_i.valid),
  .in_ready_i    (frame_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_last_i    (result_o.data.last),
  .out_channel_i (result_o.data.channel)
);

// ===== bench/imu_sample_scale_lpf_core_test.sv =====
// ----------------------------------------------------------------------------
// imu_sample_scale_lpf_core_test: self-checking bench for the frame scaler
// Drives raw sensor frames through random idle gaps, predicts the seven
// converted and filtered channel results of each frame, and compares every
// result transaction field by field across several register settings.
// ----------------------------------------------------------------------------
module imu_sample_scale_lpf_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import isl_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  isl_frame_if  frame_ch ();
  isl_result_if result_ch ();

  imu_sample_scale_lpf_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .frame_i    (frame_ch.sink),
    .result_o   (result_ch.source)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Shadow copy of the block's registers and filter states.
  logic [15:0]        mdl_weak_gain;
  logic [15:0]        mdl_strong_gain;
  logic signed [15:0] mdl_gyro_off [3];
  logic signed [63:0] mdl_weak_y [NUM_LANES];
  logic signed [63:0] mdl_strong_y [NUM_LANES];

  frame_t  frames_pending [$];
  result_t results_due [$];
  int      mismatches;
  int      hold_off_cycles;

  // Rounds to nearest with ties away from zero by working on the magnitude.
  function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
                                                    input int s);
    logic [63:0] m;
    m = v[63] ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] smooth(input logic signed [63:0] y,
                                                input logic signed [63:0] x,
                                                input logic [15:0] g);
    logic signed [63:0] acc;
    acc = $signed({48'd0, g}) * y + (64'sd65536 - $signed({48'd0, g})) * x;
    return clamp32(round_away(acc, 16));
  endfunction

  // Computes the seven channel results of one frame and advances the filters.
  task automatic convert_frame(input frame_t f);
    logic signed [63:0] phys [7];
    logic signed [15:0] raw [7];
    logic signed [15:0] neg;
    logic signed [63:0] d;
    result_t r;
    raw = '{f.accel_x_raw, f.accel_y_raw, f.accel_z_raw, f.temp_raw,
            f.gyro_x_raw, f.gyro_y_raw, f.gyro_z_raw};
    for (int k = 0; k < 3; k++) begin
      neg = -raw[k];  // 16-bit wrap keeps -32768 as is
      phys[k] = clamp32(64'(neg) * (64'sd1 <<< (FRACTION_BITS - 11)));
    end
    for (int k = 0; k < 3; k++) begin
      d = 64'(raw[4 + k]) - 64'(mdl_gyro_off[k]);
      phys[3 + k] = clamp32(round_away(d * 64'sd1170127931, 40 - FRACTION_BITS));
    end
    phys[6] = clamp32(round_away(64'(raw[3]) * 64'sd3293232779 + (64'sd21 <<< 40),
                                 40 - FRACTION_BITS));
    for (int k = 0; k < NUM_LANES; k++) begin
      mdl_weak_y[k]   = smooth(mdl_weak_y[k], phys[k], mdl_weak_gain);
      mdl_strong_y[k] = smooth(mdl_strong_y[k], phys[k], mdl_strong_gain);
    end
    for (int k = 0; k < 7; k++) begin
      r.channel         = 3'(k);
      r.physical_value  = phys[k][31:0];
      r.weak_filtered   = (k < 6) ? mdl_weak_y[k][31:0] : 32'sd0;
      r.strong_filtered = (k < 6) ? mdl_strong_y[k][31:0] : 32'sd0;
      r.last            = (k == 6);
      results_due.push_back(r);
    end
  endtask

  // Driver: offers queued frames with random idle gaps between them.
  int send_gap;
  initial begin
    frame_ch.valid = 1'b0;
    frame_ch.data  = '0;
    send_gap = 0;
  end
  always @(posedge clk_i) begin
    if (frame_ch.valid && frame_ch.ready) begin
      convert_frame(frame_ch.data);
    end
    if (!frame_ch.valid || frame_ch.ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        frame_ch.valid <= 1'b0;
      end else if (frames_pending.size() > 0) begin
        frame_ch.data  <= frames_pending.pop_front();
        frame_ch.valid <= 1'b1;
        send_gap       <= $urandom_range(0, 4);
      end else begin
        frame_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  // Ready drops for a random gap after each result, and for the whole hold-off
  // whenever the stimulus process asks for one.
  int recv_gap;
  initial begin
    result_ch.ready = 1'b0;
    recv_gap = 0;
    hold_off_cycles = 0;
    mismatches = 0;
  end
  always @(posedge clk_i) begin
    result_t want;
    if (result_ch.valid && result_ch.ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_ch.data);
      end else begin
        want = results_due.pop_front();
        if (result_ch.data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, result_ch.data);
        end
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      result_ch.ready <= 1'b0;
    end else if (result_ch.valid && result_ch.ready || recv_gap == 0) begin
      if (recv_gap > 0 || (result_ch.valid && result_ch.ready)) begin
        recv_gap <= $urandom_range(0, 4);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end else begin
      recv_gap <= recv_gap - 1;
      result_ch.ready <= 1'b0;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WEAK_GAIN:   mdl_weak_gain   = val;
      REG_STRONG_GAIN: mdl_strong_gain = val;
      REG_GYRO_OFF_X:  mdl_gyro_off[0] = val;
      REG_GYRO_OFF_Y:  mdl_gyro_off[1] = val;
      REG_GYRO_OFF_Z:  mdl_gyro_off[2] = val;
      default: ;  // unknown index is ignored by the block
    endcase
  endtask

  // Waits until every queued frame has been consumed and every result seen.
  // The state is sampled on the falling edge, once the edge updates settle.
  task automatic drain();
    while (frames_pending.size() > 0 || frame_ch.valid || results_due.size() > 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    f = 112'({$urandom, $urandom, $urandom, $urandom});
    // Now and then pin fields to the extremes.
    if ($urandom_range(0, 7) == 0) f.accel_x_raw = 16'sh8000;
    if ($urandom_range(0, 7) == 0) f.gyro_y_raw  = 16'sh7fff;
    if ($urandom_range(0, 7) == 0) f.temp_raw    = 16'sh8000;
    return f;
  endfunction

  initial begin
    frame_t f;
    logic [15:0] gain_set [5];
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_WEAK_GAIN;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    mdl_weak_gain   = WEAK_GAIN_RST;
    mdl_strong_gain = STRONG_GAIN_RST;
    for (int i = 0; i < 3; i++) mdl_gyro_off[i] = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      mdl_weak_y[i]   = '0;
      mdl_strong_y[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at reset settings: zeros, all extremes, mixed signs.
    frames_pending.push_back('0);
    frames_pending.push_back({7{16'sh7fff}});
    frames_pending.push_back({7{16'sh8000}});
    frames_pending.push_back({7{16'shffff}});
    frames_pending.push_back({16'sh8000, 16'sh7fff, 16'sh0001, 16'sh7fff,
                              16'sh8000, 16'sh7fff, 16'sh0001});
    drain();

    // Gain of zero passes samples through; maximum gain barely moves; the
    // largest offsets push the gyro difference past 16 bits.
    write_reg(REG_WEAK_GAIN, 16'd0);
    write_reg(REG_STRONG_GAIN, 16'hffff);
    write_reg(REG_GYRO_OFF_X, 16'h7fff);
    write_reg(REG_GYRO_OFF_Y, 16'h8000);
    write_reg(REG_GYRO_OFF_Z, 16'h0001);
    write_reg(3'd7, 16'h1234);  // unknown index
    write_reg(3'd5, 16'hffff);  // unknown index
    frames_pending.push_back({7{16'sh8000}});
    frames_pending.push_back({7{16'sh7fff}});
    frames_pending.push_back({7{16'sh8000}});
    frames_pending.push_back('0);
    drain();
    write_reg(REG_WEAK_GAIN, 16'hffff);
    write_reg(REG_STRONG_GAIN, 16'd0);
    frames_pending.push_back({7{16'sh7fff}});
    frames_pending.push_back({7{16'sh8000}});
    drain();

    // Random phases over several settings, each with a receiver hold-off
    // long enough that the block backs up and stalls its input.
    gain_set = '{16'd0, 16'hffff, 16'h8000, WEAK_GAIN_RST, STRONG_GAIN_RST};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_WEAK_GAIN, (ph < 5) ? gain_set[ph] : 16'($urandom));
      write_reg(REG_STRONG_GAIN, (ph < 5) ? gain_set[4 - ph] : 16'($urandom));
      write_reg(REG_GYRO_OFF_X, 16'($urandom));
      write_reg(REG_GYRO_OFF_Y, 16'($urandom));
      write_reg(REG_GYRO_OFF_Z, 16'($urandom));
      for (int n = 0; n < 70; n++) begin
        f = random_frame();
        frames_pending.push_back(f);
      end
      repeat (30) @(posedge clk_i);
      hold_off_cycles = 150;
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
